// ===== hw/rtl/bmf3_pkg.sv =====
// bmf3_pkg: widths and control/status types shared by the 3x3 box mean filter
// used by bmf3_ctrl, bmf3_datapath and box_mean_filter_3x3_unit
// no dependencies
package bmf3_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int MEAN_W     = 16;
    localparam int OROW_W     = 12;
    localparam int OCOL_W     = 10;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SLOTS  = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    // result slots of one input item, in emit order
    // bit 1 set: the result is on the current row, bit 0 set: on the current column
    localparam logic [1:0] SLOT_PREV_LEFT = 2'd0;
    localparam logic [1:0] SLOT_PREV_HERE = 2'd1;
    localparam logic [1:0] SLOT_CUR_LEFT  = 2'd2;
    localparam logic [1:0] SLOT_CUR_HERE  = 2'd3;

    typedef struct packed {
        logic       load_item;
        logic       fetch;
        logic       grid;
        logic       sum_load;
        logic       out_load;
        logic       last;
        logic [1:0] slot;
    } bmf3_cmd_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] res_mask;
    } bmf3_status_t;

endpackage

// ===== hw/rtl/box_mean_filter_3x3_unit.sv =====
// box_mean_filter_3x3_unit: top level of the streaming 3x3 box mean filter
// instantiates bmf3_ctrl and bmf3_datapath, depends on bmf3_pkg
//
// Raster samples arrive in row-major order; for every grid position the block
// emits floor(sum * 256 / count) over the in-grid 3x3 neighbours, unsigned 8.8.
// A result leaves once its lower-right neighbour is in; the row end and the
// last row flush the pending positions, so one sample causes zero to four
// transfers out, the last of them flagged by last_of_run. Items are handled
// one at a time: the line store read and window load, then a sum step and a
// multiply step per result through the shared reciprocal multiplier, the
// multiply step held while the output register holds a stalled result. The
// line stores are not cleared after reset; they are written before use within
// a frame. A write to either configuration register restarts the frame at row 0, column 0.
module box_mean_filter_3x3_unit #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bmf3_pkg::SAMPLE_W-1:0]        sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bmf3_pkg::MEAN_W-1:0]          mean_value,
    output logic [bmf3_pkg::OROW_W-1:0]          out_row,
    output logic [bmf3_pkg::OCOL_W-1:0]          out_col,
    output logic                                 last_of_run,
    output logic                                 frame_end,
    input  logic                                 cfg_we,
    input  logic [bmf3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmf3_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bmf3_pkg::*;

    bmf3_cmd_t    cmd;
    bmf3_status_t status;

    bmf3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bmf3_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .mean_value  (mean_value),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

// ===== hw/rtl/bmf3_ctrl.sv =====
// bmf3_ctrl: sequencer of the 3x3 box mean filter, one item at a time
// steps line store read, window load and the results of each item
// depends on bmf3_pkg
module bmf3_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  bmf3_pkg::bmf3_status_t status,
    output bmf3_pkg::bmf3_cmd_t    cmd
);
    import bmf3_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_GRID  = 5'b00100,
        S_SUM   = 5'b01000,
        S_MUL   = 5'b10000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [NUM_SLOTS-1:0] pend_reg;
    logic [NUM_SLOTS-1:0] pend_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           slot;
    logic [NUM_SLOTS-1:0] slot_bit;
    logic [NUM_SLOTS-1:0] rest;
    logic                 out_room;

    // lowest pending slot goes first
    always_comb
    begin
        slot = SLOT_PREV_LEFT;
        if (pend_reg[0])
        begin
            slot = SLOT_PREV_LEFT;
        end
        else if (pend_reg[1])
        begin
            slot = SLOT_PREV_HERE;
        end
        else if (pend_reg[2])
        begin
            slot = SLOT_CUR_LEFT;
        end
        else
        begin
            slot = SLOT_CUR_HERE;
        end
    end

    assign slot_bit = NUM_SLOTS'(1) << slot;
    assign rest     = pend_reg & ~slot_bit;
    assign out_room = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        cmd           = '0;
        cmd.slot      = slot;
        cmd.last      = (rest == '0);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_GRID;
            end
            S_GRID:
            begin
                cmd.grid   = 1'b1;
                pend_next  = status.res_mask;
                state_next = (status.res_mask != '0) ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (out_room)
                begin
                    cmd.out_load = 1'b1;
                    pend_next    = rest;
                    state_next   = (rest != '0) ? S_SUM : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                pend_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (pend_reg == '0))
        else $error("results still pending while idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register loaded while holding an untaken result");

    a_accept_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ((state_reg == S_FETCH) && in_stall))
        else $error("accepted item did not start a line store read");

    a_load_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> ($past(cmd.sum_load) || $past(state_reg == S_MUL)))
        else $error("result loaded without a preceding sum stage");
`endif

endmodule

// ===== hw/rtl/bmf3_datapath.sv =====
// bmf3_datapath: line stores, 3x3 window, position counters, sum and
// reciprocal multiply for the box mean, and the output register
// depends on bmf3_pkg, driven by bmf3_ctrl commands
module bmf3_datapath #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bmf3_pkg::bmf3_cmd_t                  cmd,
    output bmf3_pkg::bmf3_status_t               status,
    input  logic                                 cfg_we,
    input  logic [bmf3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmf3_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [bmf3_pkg::SAMPLE_W-1:0]        sample,
    output logic [bmf3_pkg::MEAN_W-1:0]          mean_value,
    output logic [bmf3_pkg::OROW_W-1:0]          out_row,
    output logic [bmf3_pkg::OCOL_W-1:0]          out_col,
    output logic                                 last_of_run,
    output logic                                 frame_end
);
    import bmf3_pkg::*;

    localparam int AW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;
    localparam int RECIP_W  = 24;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int RECIP_SH = 15;

    // ceil(2^23 / n): floor(sum * 256 / n) == (sum * k) >> 15 over the sum range
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] k;
        begin
            case (n)
                4'd1:    k = 24'd8388608;
                4'd2:    k = 24'd4194304;
                4'd3:    k = 24'd2796203;
                4'd4:    k = 24'd2097152;
                4'd6:    k = 24'd1398102;
                4'd9:    k = 24'd932068;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    logic [COLS_W-1:0]   cols_reg;
    logic [COLS_W-1:0]   cols_next;
    logic [ROWS_W-1:0]   rows_reg;
    logic [ROWS_W-1:0]   rows_next;
    logic [COLS_W-1:0]   col_cnt_reg;
    logic [COLS_W-1:0]   col_cnt_next;
    logic [ROWS_W-1:0]   row_cnt_reg;
    logic [ROWS_W-1:0]   row_cnt_next;

    logic [SAMPLE_W-1:0] samp_reg;
    logic [ROWS_W-1:0]   r_item_reg;
    logic [COLS_W-1:0]   c_item_reg;
    logic                lc_item_reg;
    logic                lr_item_reg;
    logic [COLS_W-1:0]   c_clamp;
    logic                last_col;
    logic                last_row;

    logic [SAMPLE_W-1:0] older_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] prior_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] older_rd_reg;
    logic [SAMPLE_W-1:0] prior_rd_reg;
    logic [AW-1:0]       addr;

    logic [SAMPLE_W-1:0] window_reg [6];
    logic [SAMPLE_W-1:0] grid_reg   [9];

    logic [2:0]          row_inc;
    logic [2:0]          col_inc;
    logic [1:0]          n_rows;
    logic [1:0]          n_cols;
    logic [CNT_W-1:0]    cnt;
    logic [SUM_W-1:0]    sum;

    logic [SUM_W-1:0]    sum_reg;
    logic [RECIP_W-1:0]  k_reg;
    logic [OROW_W-1:0]   srow_reg;
    logic [OCOL_W-1:0]   scol_reg;
    logic                slast_reg;
    logic                sfend_reg;
    logic [PROD_W-1:0]   prod;

    logic [MEAN_W-1:0]   mean_reg;
    logic [OROW_W-1:0]   orow_reg;
    logic [OCOL_W-1:0]   ocol_reg;
    logic                olast_reg;
    logic                ofend_reg;

    // configuration: zero reads as one, large values saturate
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_we && (cfg_index == CFG_COLS))
        begin
            if (cfg_data[COLS_W-1:0] == '0)
            begin
                cols_next = COLS_W'(1);
            end
            else if (int'(cfg_data[COLS_W-1:0]) > MAX_COLS)
            begin
                cols_next = COLS_W'(MAX_COLS);
            end
            else
            begin
                cols_next = cfg_data[COLS_W-1:0];
            end
        end
        if (cfg_we && (cfg_index == CFG_ROWS))
        begin
            if (cfg_data[ROWS_W-1:0] == '0)
            begin
                rows_next = ROWS_W'(1);
            end
            else if (int'(cfg_data[ROWS_W-1:0]) > MAX_ROWS)
            begin
                rows_next = ROWS_W'(MAX_ROWS);
            end
            else
            begin
                rows_next = cfg_data[ROWS_W-1:0];
            end
        end
    end

    assign last_col = ({1'b0, col_cnt_reg} + 1'b1) >= {1'b0, cols_reg};
    assign last_row = ({1'b0, row_cnt_reg} + 1'b1) >= {1'b0, rows_reg};
    assign c_clamp  = (int'(col_cnt_reg) >= MAX_COLS) ? COLS_W'(MAX_COLS - 1) : col_cnt_reg;

    // position of the next sample, restarted by any valid register write
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_we && ((cfg_index == CFG_COLS) || (cfg_index == CFG_ROWS)))
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (cmd.grid)
        begin
            if (lc_item_reg)
            begin
                col_cnt_next = '0;
                row_cnt_next = lr_item_reg ? '0 : (r_item_reg + 1'b1);
            end
            else
            begin
                col_cnt_next = c_item_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_W'(256);
            rows_reg    <= ROWS_W'(256);
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            samp_reg    <= sample;
            r_item_reg  <= row_cnt_reg;
            c_item_reg  <= c_clamp;
            lc_item_reg <= last_col;
            lr_item_reg <= last_row;
        end
    end

    assign status.res_mask[0] = (r_item_reg != '0) && (c_item_reg != '0);
    assign status.res_mask[1] = (r_item_reg != '0) && lc_item_reg;
    assign status.res_mask[2] = lr_item_reg && (c_item_reg != '0);
    assign status.res_mask[3] = lr_item_reg && lc_item_reg;

    assign addr = AW'(c_item_reg);

    // line stores: read in the fetch step, written back in the grid step
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            older_rd_reg <= older_mem[addr];
        end
        if (cmd.grid)
        begin
            older_mem[addr] <= prior_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            prior_rd_reg <= prior_mem[addr];
        end
        if (cmd.grid)
        begin
            prior_mem[addr] <= samp_reg;
        end
    end

    // window holds the two previous columns of rows r-2, r-1, r
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (cmd.grid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_reg[k*2] <= window_reg[k*2+1];
            end
            window_reg[1] <= older_rd_reg;
            window_reg[3] <= prior_rd_reg;
            window_reg[5] <= samp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                grid_reg[k*3]   <= window_reg[k*2];
                grid_reg[k*3+1] <= window_reg[k*2+1];
            end
            grid_reg[2] <= older_rd_reg;
            grid_reg[5] <= prior_rd_reg;
            grid_reg[8] <= samp_reg;
        end
    end

    // neighbours inside the grid for the slot in progress
    assign row_inc[0] = !cmd.slot[1] && (r_item_reg >= ROWS_W'(2));
    assign row_inc[1] = (r_item_reg != '0);
    assign row_inc[2] = 1'b1;
    assign col_inc[0] = !cmd.slot[0] && (c_item_reg >= COLS_W'(2));
    assign col_inc[1] = (c_item_reg != '0);
    assign col_inc[2] = 1'b1;

    assign n_rows = 2'(row_inc[0]) + 2'(row_inc[1]) + 2'(row_inc[2]);
    assign n_cols = 2'(col_inc[0]) + 2'(col_inc[1]) + 2'(col_inc[2]);
    assign cnt    = CNT_W'(n_rows) * CNT_W'(n_cols);

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_inc[k] && col_inc[j])
                begin
                    sum = sum + SUM_W'(grid_reg[k*3+j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            sum_reg   <= sum;
            k_reg     <= recip_of(cnt);
            srow_reg  <= cmd.slot[1] ? OROW_W'(r_item_reg) : OROW_W'(r_item_reg - 1'b1);
            scol_reg  <= cmd.slot[0] ? OCOL_W'(c_item_reg) : OCOL_W'(c_item_reg - 1'b1);
            slast_reg <= cmd.last;
            sfend_reg <= (cmd.slot == SLOT_CUR_HERE);
        end
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(k_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_reg  <= prod[RECIP_SH+MEAN_W-1:RECIP_SH];
            orow_reg  <= srow_reg;
            ocol_reg  <= scol_reg;
            olast_reg <= slast_reg;
            ofend_reg <= sfend_reg;
        end
    end

    assign mean_value  = mean_reg;
    assign out_row     = orow_reg;
    assign out_col     = ocol_reg;
    assign last_of_run = olast_reg;
    assign frame_end   = ofend_reg;

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for box_mean_filter_3x3_unit, the streaming 3x3 box mean
// depends on bmf3_pkg and the rtl under hw/rtl; a queue-fed driver sends samples,
// a built-in line-store predictor queues the expected means, a monitor checks them
module tb;

    import bmf3_pkg::*;

    localparam int GRID_MAX_COLS  = 1024;
    localparam int GRID_MAX_ROWS  = 4096;
    localparam int SETTLE_CYCLES  = 24;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 130;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        logic              last;
        logic              fend;
    } smoothed_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [MEAN_W-1:0]     mean_value;
    logic [OROW_W-1:0]     out_row;
    logic [OCOL_W-1:0]     out_col;
    logic                  last_of_run;
    logic                  frame_end;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_mean_filter_3x3_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mean_value  (mean_value),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [SAMPLE_W-1:0] older_line [0:GRID_MAX_COLS-1];
    logic [SAMPLE_W-1:0] prior_line [0:GRID_MAX_COLS-1];
    logic [SAMPLE_W-1:0] win [0:5];
    logic [SAMPLE_W-1:0] nbhd [0:2][0:2];
    int unsigned         cur_row = 0;
    int unsigned         cur_col = 0;
    int unsigned         grid_cols = 256;
    int unsigned         grid_rows = 256;

    logic [SAMPLE_W-1:0] pending_samples [$];
    smoothed_t           expected_means [$];
    int unsigned         queued_total = 0;
    int unsigned         taken_total = 0;
    int unsigned         mismatch_count = 0;
    logic                calm_mode = 1'b0;
    logic                squeeze_req = 1'b0;
    logic                squeeze_done = 1'b0;
    int unsigned         send_gap = 0;
    int unsigned         stall_left = 0;
    int unsigned         quiet_cycles = 0;

    function automatic int unsigned pick_delay();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mean over rows k0..2 and columns j0..2 of the window, in-grid neighbours only
    function automatic logic [MEAN_W-1:0] box_avg(input int unsigned rr, input int unsigned cc,
                                                  input int unsigned k0, input int unsigned j0);
        int unsigned sum;
        int unsigned cnt;
        int unsigned k;
        int unsigned j;
        sum = 0;
        cnt = 0;
        for (k = k0; k <= 2; k++)
        begin
            if (rr + k >= 2)
            begin
                for (j = j0; j <= 2; j++)
                begin
                    if (cc + j >= 2)
                    begin
                        sum += nbhd[k][j];
                        cnt++;
                    end
                end
            end
        end
        if (cnt == 0)
            return '0;
        return MEAN_W'((sum * 256) / cnt);
    endfunction

    task automatic predict_means(input logic [SAMPLE_W-1:0] s);
        int unsigned r;
        int unsigned c;
        int unsigned k;
        int          final_slot;
        logic [1:0]  slot;
        logic [3:0]  wanted;
        logic        last_c;
        logic        last_r;
        smoothed_t   res;
        r = cur_row;
        c = cur_col;
        last_c = (c + 1 >= grid_cols);
        last_r = (r + 1 >= grid_rows);
        if (c >= GRID_MAX_COLS)
            c = GRID_MAX_COLS - 1;
        for (k = 0; k < 3; k++)
        begin
            nbhd[k][0] = win[2 * k];
            nbhd[k][1] = win[2 * k + 1];
        end
        nbhd[0][2] = older_line[c];
        nbhd[1][2] = prior_line[c];
        nbhd[2][2] = s;
        // slot bit 1: result on the current row, bit 0: on the current column
        final_slot = -1;
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            slot = 2'(k);
            wanted[k] = (slot[1] ? last_r : (r >= 1)) && (slot[0] ? last_c : (c >= 1));
            if (wanted[k])
                final_slot = k;
        end
        for (k = 0; k < NUM_SLOTS; k++)
        begin
            slot = 2'(k);
            if (wanted[k])
            begin
                res.mean = box_avg(r, c, slot[1], slot[0]);
                res.row  = OROW_W'(slot[1] ? r : r - 1);
                res.col  = OCOL_W'(slot[0] ? c : c - 1);
                res.last = (k == final_slot);
                res.fend = (slot == SLOT_CUR_HERE);
                expected_means.push_back(res);
            end
        end
        for (k = 0; k < 3; k++)
        begin
            win[2 * k]     = nbhd[k][1];
            win[2 * k + 1] = nbhd[k][2];
        end
        older_line[c] = nbhd[1][2];
        prior_line[c] = s;
        if (last_c)
        begin
            cur_col = 0;
            cur_row = last_r ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        int unsigned v;
        if (idx == CFG_COLS)
        begin
            v = val[COLS_W-1:0];
            if (v == 0)
                v = 1;
            if (v > GRID_MAX_COLS)
                v = GRID_MAX_COLS;
            grid_cols = v;
        end
        else if (idx == CFG_ROWS)
        begin
            v = val[ROWS_W-1:0];
            if (v == 0)
                v = 1;
            if (v > GRID_MAX_ROWS)
                v = GRID_MAX_ROWS;
            grid_rows = v;
        end
        else
            return;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 93)
            return CFG_DATA_W'($urandom_range(7, 12));
        return '0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic offer(input logic [SAMPLE_W-1:0] v);
        pending_samples.push_back(v);
        queued_total++;
    endtask

    task automatic offer_random(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            offer(SAMPLE_W'($urandom_range(0, 255)));
    endtask

    // wait until every sample is taken and every mean is out, then let the block drain
    task automatic settle();
        while (taken_total != queued_total || expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_means(sample);
                taken_total++;
            end
            // a stalled transfer keeps valid and sample as they are
            if (!(in_valid && in_stall))
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    in_valid <= 1'b1;
                    sample   <= pending_samples.pop_front();
                    send_gap <= pick_delay();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result-side stall pattern, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_left   <= 0;
            squeeze_done <= 1'b0;
        end
        else if (squeeze_req && !squeeze_done)
        begin
            squeeze_done <= 1'b1;
            stall_left   <= SQUEEZE_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else
        begin : next_stall
            int unsigned d;
            d = pick_delay();
            stall_left <= d;
            out_stall  <= (d != 0);
        end
    end

    // result monitor
    always @(posedge clk)
    begin : mean_check
        smoothed_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_means.size() == 0)
            begin
                $error("unexpected result transfer: row %0d col %0d mean %0d",
                       out_row, out_col, mean_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_means.pop_front();
                if (mean_value !== want.mean)
                begin
                    $error("mean_value: expected %0d, actual %0d", want.mean, mean_value);
                    mismatch_count++;
                end
                if (out_row !== want.row)
                begin
                    $error("out_row: expected %0d, actual %0d", want.row, out_row);
                    mismatch_count++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col: expected %0d, actual %0d", want.col, out_col);
                    mismatch_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
                    mismatch_count++;
                end
                if (frame_end !== want.fend)
                begin
                    $error("frame_end: expected %0d, actual %0d", want.fend, frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned k;
        int unsigned phase;
        int unsigned count;
        int unsigned frame;
        int unsigned rand_items;
        for (k = 0; k < GRID_MAX_COLS; k++)
        begin
            older_line[k] = '0;
            prior_line[k] = '0;
        end
        for (k = 0; k < 6; k++)
            win[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset-time grid, first row only
        offer(8'h00);
        offer(8'hFF);
        offer(8'h55);
        offer(8'hAA);
        offer(8'h01);
        offer(8'h80);
        settle();

        // 3x3 grid: corner, edge and interior counts at full scale, then a wrapped frame
        write_reg(CFG_COLS, 13'd3);
        write_reg(CFG_ROWS, 13'd3);
        for (k = 0; k < 9; k++)
            offer(8'hFF);
        for (k = 0; k < 9; k++)
            offer(k[0] ? 8'hFF : 8'h00);
        settle();

        // single-position grid
        write_reg(CFG_ROWS, 13'd1);
        write_reg(CFG_COLS, 13'd1);
        offer(8'd77);
        offer(8'd0);
        settle();

        // random grids, mostly whole frames, some broken off mid-frame
        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            calm_mode <= ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                write_reg(CFG_COLS, pick_extent());
                write_reg(CFG_ROWS, pick_extent());
            end
            else if ($urandom_range(0, 1) != 0)
                write_reg(CFG_COLS, pick_extent());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom));
            frame = grid_cols * grid_rows;
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, frame);
            else
                count = frame * $urandom_range(1, 2);
            if (phase == 0)
            begin
                // long receiver hold-off so the block backs up into its input
                squeeze_req <= 1'b1;
                count += 30;
            end
            if (count > RANDOM_ITEMS - rand_items)
                count = RANDOM_ITEMS - rand_items;
            offer_random(count);
            rand_items += count;
            settle();
            phase++;
        end
        calm_mode <= 1'b0;

        // wide single-row frame, columns saturated from an oversized write, partial frame
        write_reg(CFG_COLS, 13'h1FFF);
        write_reg(CFG_ROWS, 13'd0);
        offer_random(40);
        settle();

        // single-column grid, rows saturated, partial frame
        write_reg(CFG_COLS, 13'd0);
        write_reg(CFG_ROWS, 13'h1FFF);
        offer_random(40);
        settle();

        // exact maxima, first row only so nothing comes out
        write_reg(CFG_COLS, CFG_DATA_W'(GRID_MAX_COLS));
        write_reg(CFG_ROWS, CFG_DATA_W'(GRID_MAX_ROWS));
        offer_random(30);
        settle();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== box_mean_filter_3x3_unit.f =====
hw/rtl/bmf3_pkg.sv
hw/rtl/bmf3_ctrl.sv
hw/rtl/bmf3_datapath.sv
hw/rtl/box_mean_filter_3x3_unit.sv
verif/tb.sv
